[rtl/lstw_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lstw_pkg: shared types and constants for the scan-to-world point core
// Payload structs, register map, reset values and the quarter-wave sine table.
// ----------------------------------------------------------------------------
package lstw_pkg;

  localparam int MaxBeams  = 2048;
  localparam int SineDepth = 1024;

  // Q1.15 table entries never exceed 32767
  localparam int SinW = 15;
  localparam int IdxW = $clog2(SineDepth + 1);

  localparam logic [15:0] QuarterTurn = 16'd16384;
  localparam longint unsigned HalfPiQ30 = 64'd1686629713;

  // register map
  typedef enum logic [2:0] {
    REG_RANGE_MIN     = 3'd0,
    REG_RANGE_MAX     = 3'd1,
    REG_START_ANGLE   = 3'd2,
    REG_ANGLE_STEP    = 3'd3,
    REG_MOUNT_FORWARD = 3'd4,
    REG_MOUNT_SIDE    = 3'd5,
    REG_MOUNT_YAW     = 3'd6,
    REG_SCAN_INTERVAL = 3'd7
  } cfg_reg_e;

  localparam logic [15:0] RangeMinRst   = 16'd20;
  localparam logic [15:0] RangeMaxRst   = 16'd60000;
  localparam logic [15:0] StartAngleRst = 16'd49152;
  localparam logic [11:0] AngleStepRst  = 12'd46;

  typedef struct packed {
    logic        [15:0] range_mm;
    logic        [10:0] beam_index;
    logic        [15:0] heading;
    logic signed [31:0] travel_now;
    logic signed [31:0] travel_before;
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] world_x;
    logic signed [31:0] world_y;
    logic        [10:0] point_index;
    logic               stop_alarm;
  } out_item_t;

  typedef logic [SinW-1:0] sine_rom_t [SineDepth+1];

  // long division, one quotient bit per step
  function automatic longint unsigned div_u64(input longint unsigned num,
                                              input longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Entry k = sin(pi/2 * k / SineDepth) in Q1.15, Taylor series in Q30
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t       rom;
    longint unsigned x;
    longint unsigned term;
    longint unsigned q;
    longint          sum;
    for (int k = 0; k <= SineDepth; k++) begin
      x    = (longint'(k) * HalfPiQ30) / SineDepth;
      term = x;
      sum  = longint'(x);
      for (int n = 1; n <= 8; n++) begin
        term = (((term * x) >> 30) * x) >> 30;
        term = div_u64(term, 64'((2 * n) * (2 * n + 1)));
        if ((n & 1) == 1) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      q = (longint'(sum) + 64'd16384) >> 15;
      if (q > 64'd32767) begin
        q = 64'd32767;
      end
      rom[k] = SinW'(q);
    end
    return rom;
  endfunction

endpackage
`default_nettype wire

[rtl/lidar_scan_to_world_points_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lidar_scan_to_world_points_core: range sample to world x/y point
// Filters samples on travel and range window, rotates them into world
// coordinates and latches a stop alarm for points close in front.
// ----------------------------------------------------------------------------
// One sample per cycle sustained while out_ready_i stays high; a result passes
// through five register stages before it is offered.
// Stages: input register, sine ROM read, multipliers, three-term sums with
// alarm update, rounding/origin add/saturation into the output register.
// Each stage stalls only when the one below is full, so gaps close up under
// back-pressure. Dropped samples leave the pipe after the first stage.
// Configuration is taken on any cycle but must only change while idle.
module lidar_scan_to_world_points_core import lstw_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output      logic        in_ready_o,
  input  wire in_item_t    in_data_i,
  output      logic        out_valid_o,
  input  wire logic        out_ready_i,
  output      out_item_t   out_data_o,
  input  wire logic        cfg_valid_i,
  output      logic        cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);

  // configuration
  logic        [15:0] range_min_q, range_max_q, start_angle_q, mount_yaw_q, interval_q;
  logic        [11:0] angle_step_q;
  logic signed [15:0] mount_fwd_q, mount_side_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_min_q   <= RangeMinRst;
      range_max_q   <= RangeMaxRst;
      start_angle_q <= StartAngleRst;
      angle_step_q  <= AngleStepRst;
      mount_fwd_q   <= '0;
      mount_side_q  <= '0;
      mount_yaw_q   <= '0;
      interval_q    <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_RANGE_MIN:     range_min_q   <= cfg_data_i;
        REG_RANGE_MAX:     range_max_q   <= cfg_data_i;
        REG_START_ANGLE:   start_angle_q <= cfg_data_i;
        REG_ANGLE_STEP:    angle_step_q  <= cfg_data_i[11:0];
        REG_MOUNT_FORWARD: mount_fwd_q   <= $signed(cfg_data_i);
        REG_MOUNT_SIDE:    mount_side_q  <= $signed(cfg_data_i);
        REG_MOUNT_YAW:     mount_yaw_q   <= cfg_data_i;
        REG_SCAN_INTERVAL: interval_q    <= cfg_data_i;
        default:           ;
      endcase
    end
  end

  // stage control
  logic va_q, vb_q, vc_q, vd_q, ve_q;
  logic rdy_a, rdy_b, rdy_c, rdy_d, rdy_e;

  assign rdy_e = !ve_q || out_ready_i;
  assign rdy_d = !vd_q || rdy_e;
  assign rdy_c = !vc_q || rdy_d;
  assign rdy_b = !vb_q || rdy_c;
  assign rdy_a = !va_q || rdy_b;
  assign in_ready_o = rdy_a;

  // stage A: input register
  in_item_t a_q;

  always_ff @(posedge clk_i) begin
    if (rdy_a) a_q <= in_data_i;
  end

  logic signed [32:0] travel;
  logic        [32:0] travel_abs;
  logic signed [33:0] disp;
  logic        [22:0] beam_prod;
  logic        [15:0] beam_ang, rel_ang;
  logic               keep;

  assign travel     = 33'(a_q.travel_now) - 33'(a_q.travel_before);
  assign travel_abs = travel[32] ? 33'(-travel) : 33'(travel);
  assign disp       = 34'(travel) + 34'(mount_fwd_q);
  assign beam_prod  = 23'(a_q.beam_index) * 23'(angle_step_q);
  assign beam_ang   = start_angle_q + beam_prod[15:0];
  assign rel_ang    = beam_ang - a_q.heading - mount_yaw_q;
  assign keep       = (travel_abs >= 33'(interval_q))
                   && (a_q.range_mm > range_min_q)
                   && (a_q.range_mm < range_max_q)
                   && (int'(a_q.beam_index) < MaxBeams);

  // stage B: sine ROM outputs plus carried payload
  logic signed [15:0] sin_r, cos_r, sin_h, cos_h;

  lstw_sincos u_rel_sincos (
    .clk_i   (clk_i),
    .en_i    (rdy_b),
    .angle_i (rel_ang),
    .sin_o   (sin_r),
    .cos_o   (cos_r)
  );

  lstw_sincos u_head_sincos (
    .clk_i   (clk_i),
    .en_i    (rdy_b),
    .angle_i (a_q.heading),
    .sin_o   (sin_h),
    .cos_o   (cos_h)
  );

  logic        [15:0] rng_b_q;
  logic signed [33:0] disp_b_q;
  logic signed [31:0] ox_b_q, oy_b_q;
  logic        [10:0] beam_b_q;

  always_ff @(posedge clk_i) begin
    if (rdy_b) begin
      rng_b_q  <= a_q.range_mm;
      disp_b_q <= disp;
      ox_b_q   <= a_q.origin_x;
      oy_b_q   <= a_q.origin_y;
      beam_b_q <= a_q.beam_index;
    end
  end

  // stage C: products
  logic signed [16:0] rng_s;
  logic signed [32:0] px_c_q, py_c_q;
  logic signed [49:0] chd_c_q, shd_c_q;
  logic signed [31:0] shm_c_q, chm_c_q;
  logic signed [31:0] ox_c_q, oy_c_q;
  logic        [10:0] beam_c_q;

  assign rng_s = $signed({1'b0, rng_b_q});

  always_ff @(posedge clk_i) begin
    if (rdy_c) begin
      px_c_q   <= rng_s * cos_r;
      py_c_q   <= rng_s * sin_r;
      chd_c_q  <= cos_h * disp_b_q;
      shd_c_q  <= sin_h * disp_b_q;
      shm_c_q  <= sin_h * mount_side_q;
      chm_c_q  <= cos_h * mount_side_q;
      ox_c_q   <= ox_b_q;
      oy_c_q   <= oy_b_q;
      beam_c_q <= beam_b_q;
    end
  end

  // stage D: sums and stop-zone check on the sensor-relative point
  logic signed [51:0] sum_x, sum_y;
  logic signed [33:0] rel_x, rel_y;
  logic               hit;
  logic               alarm_q;
  logic signed [51:0] sx_d_q, sy_d_q;
  logic signed [31:0] ox_d_q, oy_d_q;
  logic        [10:0] beam_d_q;
  logic               alarm_d_q;

  assign sum_x = 52'(px_c_q) + 52'(chd_c_q) + 52'(shm_c_q);
  assign sum_y = 52'(py_c_q) - 52'(shd_c_q) + 52'(chm_c_q);
  assign rel_x = (34'(px_c_q) + 34'sd16384) >>> 15;
  assign rel_y = (34'(py_c_q) + 34'sd16384) >>> 15;
  assign hit   = (rel_y < 34'sd1000) && (rel_x < 34'sd100) && (rel_x > -34'sd100);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alarm_q <= 1'b0;
    end else if (rdy_d && vc_q && hit) begin
      alarm_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_d) begin
      sx_d_q    <= sum_x;
      sy_d_q    <= sum_y;
      ox_d_q    <= ox_c_q;
      oy_d_q    <= oy_c_q;
      beam_d_q  <= beam_c_q;
      alarm_d_q <= alarm_q || (vc_q && hit);
    end
  end

  // stage E: round, add origin, saturate
  function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
    if (v > 38'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (v < -38'sd2147483648) begin
      return 32'sh80000000;
    end
    return 32'(v);
  endfunction

  logic signed [51:0] rnd_x, rnd_y;
  logic signed [37:0] wx, wy;
  out_item_t          e_q;

  assign rnd_x = (sx_d_q + 52'sd16384) >>> 15;
  assign rnd_y = (sy_d_q + 52'sd16384) >>> 15;
  assign wx    = 38'(rnd_x) + 38'(ox_d_q);
  assign wy    = 38'(rnd_y) + 38'(oy_d_q);

  always_ff @(posedge clk_i) begin
    if (rdy_e) begin
      e_q.world_x     <= sat32(wx);
      e_q.world_y     <= sat32(wy);
      e_q.point_index <= beam_d_q;
      e_q.stop_alarm  <= alarm_d_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
      ve_q <= 1'b0;
    end else begin
      if (rdy_a) va_q <= in_valid_i;
      if (rdy_b) vb_q <= va_q && keep;
      if (rdy_c) vc_q <= vb_q;
      if (rdy_d) vd_q <= vc_q;
      if (rdy_e) ve_q <= vd_q;
    end
  end

  assign out_valid_o = ve_q;
  assign out_data_o  = e_q;

  // the alarm is sticky
  assert property (@(posedge clk_i) disable iff (!rst_ni) !$fell(alarm_q))
    else $error("stop alarm cleared without reset");

  // an alarm shown on a result must already be latched
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   out_valid_o && out_data_o.stop_alarm |-> alarm_q)
    else $error("result alarm set but latch clear");

  // input only held off when every stage is occupied
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   !in_ready_o |-> (va_q && vb_q && vc_q && vd_q && ve_q))
    else $error("input stalled with a bubble in the pipe");

endmodule
`default_nettype wire

[rtl/lstw_sincos.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lstw_sincos: sine and cosine of a binary angle
// Quarter-wave ROM with two registered read ports; quadrant folding on the
// address side, sign applied after the read.
// ----------------------------------------------------------------------------
module lstw_sincos import lstw_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               en_i,
  input  wire logic        [15:0] angle_i,
  output      logic signed [15:0] sin_o,
  output      logic signed [15:0] cos_o
);

  localparam sine_rom_t Rom = build_sine_rom();
  localparam int ProdW = 14 + IdxW;

  logic [15:0]     cos_ang;
  logic [IdxW-1:0] sin_addr, cos_addr;
  logic [SinW-1:0] sin_data_q, cos_data_q;
  logic            sin_neg_q, cos_neg_q;

  function automatic logic [IdxW-1:0] fold_addr(input logic [15:0] ang);
    logic [ProdW-1:0] prod;
    logic [IdxW-1:0]  idx;
    prod = ProdW'(ang[13:0]) * ProdW'(SineDepth);
    idx  = prod[ProdW-1:14];
    // odd quadrants run the table backwards
    return ang[14] ? (IdxW'(SineDepth) - idx) : idx;
  endfunction

  assign cos_ang  = angle_i + QuarterTurn;
  assign sin_addr = fold_addr(angle_i);
  assign cos_addr = fold_addr(cos_ang);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sin_data_q <= Rom[sin_addr];
      cos_data_q <= Rom[cos_addr];
      sin_neg_q  <= angle_i[15];
      cos_neg_q  <= cos_ang[15];
    end
  end

  assign sin_o = sin_neg_q ? -$signed({1'b0, sin_data_q}) : $signed({1'b0, sin_data_q});
  assign cos_o = cos_neg_q ? -$signed({1'b0, cos_data_q}) : $signed({1'b0, cos_data_q});

endmodule
`default_nettype wire
